// ----- rtl/core/fqd_pkg.sv -----
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared sizes, field layout and codes of the queue with delete by key.
// ----------------------------------------------------------------------------
package fqd_pkg;

   // Storage sizes.
   localparam int QUEUE_DEPTH = 16;
   localparam int KEY_WIDTH   = 16;
   localparam int ADDR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Field widths on the streams.
   localparam int OP_FIELD_WIDTH     = 2;
   localparam int KEY_FIELD_WIDTH    = 16;
   localparam int STATUS_FIELD_WIDTH = 2;
   localparam int COUNT_FIELD_WIDTH  = 5;

   // Request tdata: op, task_key, zero fill.
   localparam int REQ_OP_LSB      = 0;
   localparam int REQ_KEY_LSB     = REQ_OP_LSB + OP_FIELD_WIDTH;
   localparam int REQ_USED_WIDTH  = REQ_KEY_LSB + KEY_FIELD_WIDTH;
   localparam int REQ_TDATA_WIDTH = ((REQ_USED_WIDTH + 7) / 8) * 8;

   // Response tdata: out_key, hit, status, count.
   localparam int RSP_KEY_LSB     = 0;
   localparam int RSP_HIT_LSB     = RSP_KEY_LSB + KEY_FIELD_WIDTH;
   localparam int RSP_STATUS_LSB  = RSP_HIT_LSB + 1;
   localparam int RSP_COUNT_LSB   = RSP_STATUS_LSB + STATUS_FIELD_WIDTH;
   localparam int RSP_USED_WIDTH  = RSP_COUNT_LSB + COUNT_FIELD_WIDTH;
   localparam int RSP_TDATA_WIDTH = ((RSP_USED_WIDTH + 7) / 8) * 8;

   typedef logic [OP_FIELD_WIDTH-1:0]     op_type;
   typedef logic [STATUS_FIELD_WIDTH-1:0] status_type;

   localparam op_type OP_ENQUEUE = 2'd0;
   localparam op_type OP_DEQUEUE = 2'd1;
   localparam op_type OP_DELETE  = 2'd2;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_EMPTY     = 2'd1;
   localparam status_type ST_FULL      = 2'd2;
   localparam status_type ST_NOT_FOUND = 2'd3;

endpackage

// ----- rtl/core/fqd_ram.sv -----
// ----------------------------------------------------------------------------
// fqd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fqd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/fifo_queue_with_delete.sv -----
// ----------------------------------------------------------------------------
// fifo_queue_with_delete
// Bounded FIFO of task keys with enqueue, dequeue and delete of the first
// matching key; later entries close the gap in order.
// ----------------------------------------------------------------------------
//   Channel   Direction  Payload
//   req_*     in         op, task_key
//   rsp_*     out        out_key, hit, status, count
//
// Enqueue, unused ops and operations on an empty queue go from IDLE straight
// to DONE. Dequeue and delete on a non-empty queue make one pass over the stored
// entries through the RAM read port and the key comparator, one entry per cycle.
// Reset is synchronous and empties the queue; entries are never cleared.
// A new transaction is taken while the previous response waits; a stalled
// response holds the block in its final state until it is taken.
module fifo_queue_with_delete (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // op [1:0], task_key [17:2], zero [23:18]
   input  logic [fqd_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_key [15:0], hit [16], status [18:17], count [23:19]
   output logic [fqd_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   import fqd_pkg::*;

   typedef enum logic [2:0] {
      IDLE = 3'b001,
      SCAN = 3'b010,
      DONE = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   logic [COUNT_WIDTH-1:0]     count_ff, count_in;
   logic [COUNT_WIDTH-1:0]     rd_idx_ff, rd_idx_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic [ADDR_WIDTH-1:0]      pend_idx_ff, pend_idx_in;
   logic                       found_ff, found_in;
   logic [KEY_WIDTH-1:0]       key_ff, key_in;
   op_type                     op_ff, op_in;
   logic [KEY_FIELD_WIDTH-1:0] res_key_ff, res_key_in;
   logic                       res_hit_ff, res_hit_in;
   status_type                 res_status_ff, res_status_in;
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic                       wr_en;
   logic [ADDR_WIDTH-1:0]      wr_addr;
   logic [KEY_WIDTH-1:0]       wr_data;
   logic                       rd_en;
   logic [ADDR_WIDTH-1:0]      rd_addr;
   logic [KEY_WIDTH-1:0]       rd_data;

   op_type                     req_op;
   logic [KEY_WIDTH-1:0]       req_key;
   logic                       key_match;
   logic                       entry_hit;

   fqd_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_op  = req_tdata[REQ_KEY_LSB-1:REQ_OP_LSB];
   assign req_key = KEY_WIDTH'(req_tdata[REQ_USED_WIDTH-1:REQ_KEY_LSB]);

   // The one comparator: the entry just read against the key held.
   assign key_match = (rd_data == key_ff);
   // A dequeue removes the front entry; a delete the first matching one.
   assign entry_hit = (op_ff == OP_DEQUEUE) ? (pend_idx_ff == '0) : key_match;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      pend_valid_in = 1'b0;
      pend_idx_in   = pend_idx_ff;
      found_in      = found_ff;
      key_in        = key_ff;
      op_in         = op_ff;
      res_key_in    = res_key_ff;
      res_hit_in    = res_hit_ff;
      res_status_in = res_status_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[ADDR_WIDTH-1:0];
      wr_data       = req_key;
      rd_en         = 1'b0;
      rd_addr       = rd_idx_ff[ADDR_WIDTH-1:0];

      case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               key_in        = req_key;
               op_in         = req_op;
               rd_idx_in     = '0;
               found_in      = 1'b0;
               res_key_in    = '0;
               res_hit_in    = 1'b0;
               res_status_in = ST_OK;
               state_in      = DONE;
               case (req_op)
                  OP_ENQUEUE: begin
                     if (count_ff == COUNT_WIDTH'(QUEUE_DEPTH)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        wr_en      = 1'b1;
                        count_in   = count_ff + COUNT_WIDTH'(1);
                        res_hit_in = 1'b1;
                     end
                  end
                  OP_DEQUEUE: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        state_in = SCAN;
                     end
                  end
                  OP_DELETE: begin
                     res_status_in = ST_NOT_FOUND;
                     if (count_ff != '0) begin
                        state_in = SCAN;
                     end
                  end
                  default: begin
                     state_in = DONE;
                  end
               endcase
            end
         end
         SCAN: begin
            // Each read is issued in the cycle before its compare and write-back.
            if (rd_idx_ff < count_ff) begin
               rd_en         = 1'b1;
               pend_valid_in = 1'b1;
               pend_idx_in   = rd_idx_ff[ADDR_WIDTH-1:0];
               rd_idx_in     = rd_idx_ff + COUNT_WIDTH'(1);
            end
            if (pend_valid_ff) begin
               if (found_ff) begin
                  // Past the removed entry: move each one down by one place.
                  wr_en   = 1'b1;
                  wr_addr = pend_idx_ff - ADDR_WIDTH'(1);
                  wr_data = rd_data;
               end else if (entry_hit) begin
                  found_in      = 1'b1;
                  res_hit_in    = 1'b1;
                  res_status_in = ST_OK;
                  if (op_ff == OP_DEQUEUE) begin
                     res_key_in = KEY_FIELD_WIDTH'(rd_data);
                  end
               end
            end else if (rd_idx_ff >= count_ff) begin
               state_in = DONE;
               if (found_ff) begin
                  count_in = count_ff - COUNT_WIDTH'(1);
               end
            end
         end
         DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = '0;
               rsp_tdata_in[RSP_HIT_LSB-1:RSP_KEY_LSB]       = res_key_ff;
               rsp_tdata_in[RSP_HIT_LSB]                     = res_hit_ff;
               rsp_tdata_in[RSP_COUNT_LSB-1:RSP_STATUS_LSB]  = res_status_ff;
               rsp_tdata_in[RSP_USED_WIDTH-1:RSP_COUNT_LSB]  =
                  COUNT_FIELD_WIDTH'(count_ff);
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      pend_idx_ff   <= pend_idx_in;
      found_ff      <= found_in;
      key_ff        <= key_in;
      op_ff         <= op_in;
      res_key_ff    <= res_key_in;
      res_hit_ff    <= res_hit_in;
      res_status_ff <= res_status_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ----- rtl/core/fqd_checker.sv -----
// ----------------------------------------------------------------------------
// fqd_checker
// Port-level checks of the queue with delete, bound to the top level.
// ----------------------------------------------------------------------------
module fqd_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [fqd_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [fqd_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   import fqd_pkg::*;

   logic [COUNT_FIELD_WIDTH-1:0] rsp_count;
   status_type                   rsp_status;
   logic                         rsp_hit;

   assign rsp_count  = rsp_tdata[RSP_USED_WIDTH-1:RSP_COUNT_LSB];
   assign rsp_status = rsp_tdata[RSP_COUNT_LSB-1:RSP_STATUS_LSB];
   assign rsp_hit    = rsp_tdata[RSP_HIT_LSB];

   // A stalled response transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Every operation leaves IDLE on acceptance, so the block is busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted in back-to-back cycles");

   // A successful operation always reports the ok status.
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_hit |-> rsp_status == ST_OK)
      else $error("hit with non-ok status");

   // The reported count never exceeds the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_count <= COUNT_FIELD_WIDTH'(QUEUE_DEPTH))
      else $error("count beyond queue depth");

   // Reset leaves no response pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind fifo_queue_with_delete fqd_checker u_fqd_checker (.*);

// ----- test/fifo_queue_with_delete_tb.sv -----
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_tb
// Drives enqueue, dequeue, delete and unused operations into the queue and
// checks every response against a queue-based prediction. A directed pass
// covers empty, full, duplicate keys and misses. Random traffic then runs
// under changing backpressure on both channels, including a long response
// stall that fills the block.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fqd_pkg::*;

   localparam op_type OP_UNUSED   = 2'd3;
   localparam int     CYCLE_LIMIT = 400000;
   localparam int     HOLD_CYCLES = 300;

   typedef struct packed {
      logic [KEY_FIELD_WIDTH-1:0]   out_key;
      logic                         hit;
      status_type                   status;
      logic [COUNT_FIELD_WIDTH-1:0] count;
   } rsp_fields_type;

   class queue_scoreboard;
      logic [KEY_FIELD_WIDTH-1:0] held_keys[$];
      rsp_fields_type             expected_rsps[$];
      int                         errors = 0;

      // Applies one accepted transaction to the predicted queue.
      function void note_request(logic [REQ_TDATA_WIDTH-1:0] tdata);
         op_type                     op;
         logic [KEY_FIELD_WIDTH-1:0] key;
         rsp_fields_type             rsp;
         bit                         found;
         op    = tdata[REQ_OP_LSB +: OP_FIELD_WIDTH];
         key   = tdata[REQ_KEY_LSB +: KEY_FIELD_WIDTH];
         rsp   = '0;
         found = 0;
         case (op)
            OP_ENQUEUE: begin
               if (held_keys.size() >= QUEUE_DEPTH) begin
                  rsp.status = ST_FULL;
               end else begin
                  held_keys.push_back(key);
                  rsp.hit = 1'b1;
               end
            end
            OP_DEQUEUE: begin
               if (held_keys.size() == 0) begin
                  rsp.status = ST_EMPTY;
               end else begin
                  rsp.out_key = held_keys.pop_front();
                  rsp.hit     = 1'b1;
               end
            end
            OP_DELETE: begin
               rsp.status = ST_NOT_FOUND;
               for (int i = 0; i < held_keys.size() && !found; i++) begin
                  if (held_keys[i] == key) begin
                     held_keys.delete(i);
                     found      = 1;
                     rsp.hit    = 1'b1;
                     rsp.status = ST_OK;
                  end
               end
            end
            default: begin
            end
         endcase
         rsp.count = COUNT_FIELD_WIDTH'(held_keys.size());
         expected_rsps.push_back(rsp);
      endfunction

      function void check_response(logic [RSP_TDATA_WIDTH-1:0] tdata);
         rsp_fields_type want;
         rsp_fields_type got;
         got.out_key = tdata[RSP_KEY_LSB +: KEY_FIELD_WIDTH];
         got.hit     = tdata[RSP_HIT_LSB];
         got.status  = tdata[RSP_STATUS_LSB +: STATUS_FIELD_WIDTH];
         got.count   = tdata[RSP_COUNT_LSB +: COUNT_FIELD_WIDTH];
         if (expected_rsps.size() == 0) begin
            $error("response transaction with nothing pending: tdata %h", tdata);
            errors++;
            return;
         end
         want = expected_rsps.pop_front();
         if (got.out_key !== want.out_key) begin
            $error("out_key mismatch: expected %h, actual %h", want.out_key, got.out_key);
            errors++;
         end
         if (got.hit !== want.hit) begin
            $error("hit mismatch: expected %b, actual %b", want.hit, got.hit);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
         if (got.count !== want.count) begin
            $error("count mismatch: expected %0d, actual %0d", want.count, got.count);
            errors++;
         end
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;

   queue_scoreboard sb = new();

   int          rsp_stall_pct = 0;
   int unsigned hold_token = 0;
   int unsigned hold_seen  = 0;
   int          hold_left  = 0;
   int          cycles     = 0;

   logic [KEY_FIELD_WIDTH-1:0] key_pool[8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                               16'h1234, 16'hA5A5, 16'h5A5A, 16'h7FFF};

   fifo_queue_with_delete dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Both channels are observed here so that prediction and checking share
   // one view of each edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_request(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata);
         end
      end
   end

   // Response side backpressure; a long hold-off starts when the token moves.
   always @(posedge clock) begin
      logic ready;
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         ready = 1'b0;
      end else begin
         ready = ($urandom_range(99) >= rsp_stall_pct);
      end
      rsp_tready <= ready;
   end

   task automatic send_item(input op_type op, input logic [KEY_FIELD_WIDTH-1:0] key,
                            input int idle_pct);
      logic [REQ_TDATA_WIDTH-1:0] word;
      word = '0;
      word[REQ_OP_LSB +: OP_FIELD_WIDTH]   = op;
      word[REQ_KEY_LSB +: KEY_FIELD_WIDTH] = key;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering and waits until every response has been taken.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic send_random(input int n, input int idle_pct);
      int     enq_weight;
      int     r;
      op_type op;
      logic [KEY_FIELD_WIDTH-1:0] key;
      enq_weight = 40;
      for (int i = 0; i < n; i++) begin
         // Switch at random between filling and emptying runs so both ends are hit.
         if (i % 20 == 0) begin
            enq_weight = $urandom_range(1) ? 70 : 25;
         end
         r = $urandom_range(99);
         if (r < 4) begin
            op = OP_UNUSED;
         end else if (r < 4 + enq_weight) begin
            op = OP_ENQUEUE;
         end else if ((r - enq_weight) % 2 == 0) begin
            op = OP_DEQUEUE;
         end else begin
            op = OP_DELETE;
         end
         if ($urandom_range(99) < 75) begin
            key = key_pool[$urandom_range(7)];
         end else begin
            key = KEY_FIELD_WIDTH'($urandom);
         end
         send_item(op, key, idle_pct);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty cases, unused op, duplicates, misses, full queue.
      send_item(OP_DEQUEUE, 16'hFFFF, 0);
      send_item(OP_DELETE, 16'h0000, 0);
      send_item(OP_UNUSED, 16'hFFFF, 0);
      send_item(OP_ENQUEUE, 16'h0000, 0);
      send_item(OP_ENQUEUE, 16'hFFFF, 0);
      send_item(OP_ENQUEUE, 16'hAAAA, 0);
      send_item(OP_ENQUEUE, 16'h5555, 0);
      send_item(OP_ENQUEUE, 16'hFFFF, 0);
      send_item(OP_DELETE, 16'hFFFF, 0);
      send_item(OP_DELETE, 16'h1234, 0);
      send_item(OP_DEQUEUE, 16'h0000, 0);
      for (int i = 1; i <= 13; i++) begin
         send_item(OP_ENQUEUE, 16'h1111 * i[15:0], 0);
      end
      send_item(OP_ENQUEUE, 16'hBEEF, 0);
      send_item(OP_UNUSED, 16'h0000, 0);
      send_item(OP_DELETE, 16'hDDDD, 0);
      send_item(OP_DELETE, 16'hAAAA, 0);
      drain();

      rsp_stall_pct = 0;
      send_random(145, 0);
      drain();

      rsp_stall_pct = 0;
      send_random(145, 59);
      drain();

      rsp_stall_pct = 59;
      send_random(145, 0);
      drain();

      rsp_stall_pct = 11;
      send_random(145, 11);

      // The response side holds off while requests keep coming, so the
      // block backs up and stops accepting transactions.
      rsp_stall_pct = 0;
      hold_token <= hold_token + 1;
      send_random(30, 0);
      drain();

      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- fifo_queue_with_delete.f -----
rtl/core/fqd_pkg.sv
rtl/core/fqd_ram.sv
rtl/core/fifo_queue_with_delete.sv
rtl/core/fqd_checker.sv
test/fifo_queue_with_delete_tb.sv
